### hw/rtl/sef_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge filter package
// Shared pixel types, configuration register codes, sizes and the per
// channel edge magnitude arithmetic used by the Sobel edge filter.
// ----------------------------------------------------------------------------
package sef_pkg;

    // Default largest row length held in the line stores.
    localparam int MAX_WIDTH_DEF = 256;
    // Rows per frame are clamped to this many.
    localparam int HEIGHT_LIMIT  = 256;
    // Width of the configuration registers and of the row counter.
    localparam int CFG_W         = 9;
    localparam int ROW_W         = 9;
    localparam logic [ROW_W-1:0] ROW_SAT   = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);
    // Result queue depth at the output.
    localparam int OUT_DEPTH     = 4;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       fill;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One window column: top, middle and bottom pixel.
    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    // One line store entry: the row two above and the row one above.
    typedef struct packed {
        t_rgb upper;
        t_rgb lower;
    } t_ls_word;

    // Control carried from the accept stage to the line store stage.
    typedef struct packed {
        logic vld;
        logic up_en;
        logic lo_en;
        logic icz;
        logic emit;
        logic fend;
        t_rgb pix;
    } t_ctl_b;

    // Window columns carried to the arithmetic stage.
    typedef struct packed {
        logic vld;
        logic fend;
        t_col left;
        t_col right;
    } t_stage_c;

    // Horizontal Sobel response of one channel, magnitude clamped to 255.
    function automatic logic [7:0] chan_edge(
        input logic [7:0] lt, input logic [7:0] lm, input logic [7:0] lb,
        input logic [7:0] rt, input logic [7:0] rm, input logic [7:0] rb
    );
        logic signed [10:0] g;
        logic        [10:0] mag;
        g = $signed({3'b000, rt}) - $signed({3'b000, lt})
          + (($signed({3'b000, rm}) - $signed({3'b000, lm})) <<< 1)
          + $signed({3'b000, rb}) - $signed({3'b000, lb});
        mag = g[10] ? 11'(-g) : 11'(g);
        return (mag > 11'd255) ? 8'hFF : mag[7:0];
    endfunction

    function automatic t_rgb rgb_edge(input t_col l, input t_col r);
        t_rgb res;
        res.red   = chan_edge(l.top.red, l.mid.red, l.bot.red,
                              r.top.red, r.mid.red, r.bot.red);
        res.green = chan_edge(l.top.green, l.mid.green, l.bot.green,
                              r.top.green, r.mid.green, r.bot.green);
        res.blue  = chan_edge(l.top.blue, l.mid.blue, l.bot.blue,
                              r.top.blue, r.mid.blue, r.bot.blue);
        return res;
    endfunction

endpackage

### hw/rtl/sobel_edge_filter_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge filter unit
// Streaming 3x3 horizontal Sobel edge magnitude on RGB pixels in raster
// order, with line stores, a two-cell window chain and a result queue.
// ----------------------------------------------------------------------------
// The unit takes one pixel beat per clock while input ready is high and, in
// steady state, delivers one result beat per clock. The result for a centre
// pixel is produced by the input beat that arrives image_width+1 beats later;
// it passes through the line store read register and the window stage
// register, whose kernel arithmetic feeds the result queue directly. The
// line store memory is read and written once per beat, which sets the one
// beat per clock figure. After the last pixel of a frame, image_width+1 fill
// beats flush the remaining results; the last one carries frame_end. Input
// ready is low while four result beats are in flight or queued, which
// happens only when the output side falls behind.
module sobel_edge_filter_unit
    import sef_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  t_cfg_reg           i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_pix_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_pix_out           o_out_data
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int EW   = ($clog2(MAX_WIDTH+1) > CFG_W) ? $clog2(MAX_WIDTH+1) : CFG_W;
    localparam int CNTW = EW + CFG_W;
    localparam int UW   = $clog2(OUT_DEPTH+1);

    // Effective width: zero acts as one, large values clamp to the store size.
    function automatic logic [EW-1:0] eff_width(input logic [CFG_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (v == '0) begin
            return EW'(1);
        end else if (ext > EW'(MAX_WIDTH)) begin
            return EW'(MAX_WIDTH);
        end
        return ext;
    endfunction

    function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CFG_W'(1);
        end else if (v > CFG_W'(HEIGHT_LIMIT)) begin
            return CFG_W'(HEIGHT_LIMIT);
        end
        return v;
    endfunction

    // Configuration and position state.
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CFG_W-1:0] n_width;
    logic [CFG_W-1:0] n_height;
    logic [CNTW-1:0]  r_area;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COLW-1:0]  r_col_idx;
    logic [COLW-1:0]  n_col_idx;
    logic [CNTW-1:0]  r_emit_cnt;
    logic [CNTW-1:0]  n_emit_cnt;
    logic [UW-1:0]    r_used;
    logic [UW-1:0]    n_used;

    logic             in_acc;
    logic             out_acc;
    logic [EW-1:0]    w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             a_emit;
    logic             a_last_col;
    logic             a_fend;
    logic             a_pix_en;

    // Pipeline stages.
    t_ctl_b           r_b;
    logic [COLW-1:0]  r_b_col;
    t_stage_c         r_c;
    t_ls_word         lb_rd;
    t_ls_word         lb_wr;
    t_col             newcol;
    t_col             cell_new_q;
    t_col             cell_old_q;
    t_pix_out         c_res;
    t_rgb             c_edge;
    logic [UW-1:0]    fifo_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_used < UW'(OUT_DEPTH));
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    // Configuration register decode.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data;
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // Frame area is registered at the same edge as the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
            r_area   <= CNTW'(eff_width(CFG_RESET)) * CNTW'(eff_height(CFG_RESET));
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_area   <= CNTW'(eff_width(n_width)) * CNTW'(eff_height(n_height));
        end
    end

    // Position tracking and output decision at the accept stage.
    always_comb begin
        w_eff      = eff_width(r_width);
        h_eff      = eff_height(r_height);
        a_emit     = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && (r_col_idx != '0));
        a_last_col = ((EW+1)'(r_col_idx) + 1'b1) >= (EW+1)'(w_eff);
        a_fend     = a_emit && (((CNTW+1)'(r_emit_cnt) + 1'b1) >= (CNTW+1)'(r_area));
        a_pix_en   = !i_in_data.fill && (r_row < h_eff);

        n_row      = r_row;
        n_col_idx  = r_col_idx;
        n_emit_cnt = r_emit_cnt;
        if (in_acc) begin
            if (a_last_col) begin
                n_col_idx = '0;
                n_row     = (r_row == ROW_SAT) ? r_row : r_row + 1'b1;
            end else begin
                n_col_idx = r_col_idx + 1'b1;
            end
            if (a_emit) begin
                if (a_fend) begin
                    n_row      = '0;
                    n_col_idx  = '0;
                    n_emit_cnt = '0;
                end else begin
                    n_emit_cnt = r_emit_cnt + 1'b1;
                end
            end
        end
        n_used = r_used + UW'(in_acc && a_emit) - UW'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col_idx  <= '0;
            r_emit_cnt <= '0;
            r_used     <= '0;
            r_b.vld    <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col_idx  <= n_col_idx;
            r_emit_cnt <= n_emit_cnt;
            r_used     <= n_used;
            r_b.vld    <= in_acc;
        end
        // Stage B payload.
        if (in_acc) begin
            r_b.up_en <= (r_row >= ROW_W'(2));
            r_b.lo_en <= (r_row >= ROW_W'(1));
            r_b.icz   <= (r_col_idx == '0);
            r_b.emit  <= a_emit;
            r_b.fend  <= a_fend;
            r_b.pix   <= a_pix_en ? t_rgb'({i_in_data.red_in, i_in_data.green_in,
                                            i_in_data.blue_in}) : t_rgb'('0);
            r_b_col   <= r_col_idx;
        end
    end

    sef_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col_idx),
        .i_wr_en   (r_b.vld),
        .i_wr_addr (r_b_col),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    // New column from the line stores and the incoming pixel.
    always_comb begin
        newcol.top   = r_b.up_en ? lb_rd.upper : t_rgb'('0);
        newcol.mid   = r_b.lo_en ? lb_rd.lower : t_rgb'('0);
        newcol.bot   = r_b.pix;
        lb_wr.upper  = newcol.mid;
        lb_wr.lower  = r_b.pix;
    end

    // Window chain: the newest column feeds the older one.
    sef_col_cell u_cell_new (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_b.vld),
        .i_zero  (1'b0),
        .i_clr   (r_b.vld && r_b.fend),
        .i_col   (newcol),
        .o_col   (cell_new_q)
    );

    sef_col_cell u_cell_old (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_b.vld),
        .i_zero  (r_b.icz),
        .i_clr   (r_b.vld && r_b.fend),
        .i_col   (cell_new_q),
        .o_col   (cell_old_q)
    );

    // Stage C: columns on either side of the centre pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else begin
            r_c.vld <= r_b.vld && r_b.emit;
        end
        if (r_b.vld) begin
            r_c.fend  <= r_b.fend;
            r_c.left  <= cell_old_q;
            r_c.right <= r_b.icz ? t_col'('0) : newcol;
        end
    end

    // Kernel arithmetic for all three channels.
    always_comb begin
        c_edge           = rgb_edge(r_c.left, r_c.right);
        c_res.red_edge   = c_edge.red;
        c_res.green_edge = c_edge.green;
        c_res.blue_edge  = c_edge.blue;
        c_res.frame_end  = r_c.fend;
    end

    sef_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_c.vld),
        .i_data  (c_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data),
        .o_count (fifo_count)
    );

    // Credits never exceed the queue size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(OUT_DEPTH))
        else $error("result credit count exceeds queue depth");

    // Every queued beat still holds its credit.
    a_fifo_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= r_used)
        else $error("queue holds more beats than credits");

    // A beat about to enter the queue always has room.
    a_stage_c_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c.vld |-> (r_used > fifo_count))
        else $error("arithmetic stage result without a credit");

    // The frame-end beat returns the position to the frame start.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && a_fend) |=> (r_row == '0 && r_col_idx == '0 && r_emit_cnt == '0))
        else $error("position not reset after frame end");

endmodule

### hw/rtl/sef_line_buf.sv
// ----------------------------------------------------------------------------
// Sobel edge filter line stores
// Both past rows share one memory word per column. Read is registered; the
// memory array itself is read-first, and a write to the column read in the
// same cycle is forwarded, so the read returns the new word.
// ----------------------------------------------------------------------------
module sef_line_buf
    import sef_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  t_ls_word                     i_wr_data,
    output t_ls_word                     o_rd_data
);

    t_ls_word r_mem [MAX_WIDTH];
    t_ls_word r_q;
    t_ls_word r_fwd_data;
    logic     r_fwd;

    // Memory array with read-first behavior.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Bypass for a write to the column read at the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

### hw/rtl/sef_col_cell.sv
// ----------------------------------------------------------------------------
// Sobel edge filter window cell
// Holds one three-pixel column of the window and takes its neighbor's
// column on every beat; it can load zeros at a row start or clear at frame end.
// ----------------------------------------------------------------------------
module sef_col_cell
    import sef_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_zero,
    input  logic i_clr,
    input  t_col i_col,
    output t_col o_col
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_clr) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_zero ? t_col'('0) : i_col;
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/sef_out_fifo.sv
// ----------------------------------------------------------------------------
// Sobel edge filter result queue
// Small queue between the arithmetic stage and the output channel, so the
// pipeline keeps moving while a result beat waits to be taken.
// ----------------------------------------------------------------------------
module sef_out_fifo
    import sef_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_pix_out                   i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_pix_out                   o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_pix_out        r_buf [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge filter unit testbench
// Streams RGB frames of many sizes through the unit and predicts every edge
// beat, including the frame_end flag. The predictor keeps its own line
// stores, window and position. A clocked driver feeds pixel beats from a
// queue, a clocked monitor checks each result beat against the oldest
// prediction, and both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import sef_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 1000;

    // Hand-picked 3x3 frame: full-scale steps, a fill beat inside the frame
    // and pixel beats among the flush beats.
    localparam t_pix_in CORNER_FRAME [13] = '{
        {8'hFF, 8'hFF, 8'hFF, 1'b0}, {8'h00, 8'h00, 8'h00, 1'b0},
        {8'hFF, 8'h00, 8'h80, 1'b0}, {8'h00, 8'hFF, 8'h00, 1'b0},
        {8'h12, 8'h34, 8'h56, 1'b1}, {8'hFF, 8'hFF, 8'hFF, 1'b0},
        {8'hFF, 8'hFF, 8'hFF, 1'b0}, {8'h00, 8'h00, 8'h00, 1'b0},
        {8'hFF, 8'hFF, 8'hFF, 1'b0}, {8'h00, 8'h00, 8'h00, 1'b1},
        {8'hFF, 8'hFF, 8'hFF, 1'b0}, {8'hAA, 8'h55, 8'hAA, 1'b1},
        {8'h01, 8'h02, 8'h03, 1'b1}
    };

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_reg         i_cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_pix_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_pix_out         o_out_data;

    // Stimulus and expectation stores.
    t_pix_in  pixels_to_send [$];
    t_pix_out edges_due [$];
    int       queued_items  = 0;
    int       fail_count    = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_req      = 0;
    int       hold_ack      = 0;
    int       hold_left     = 0;
    int       quiet_cycles  = 0;

    // Predictor state: line stores, window columns, position and setup.
    t_rgb             upper_line [MAX_WIDTH_DEF];
    t_rgb             lower_line [MAX_WIDTH_DEF];
    t_col             win_newest = '0;
    t_col             win_prior  = '0;
    int               pos_row    = 0;
    int               pos_col    = 0;
    int               emitted    = 0;
    logic [CFG_W-1:0] cfg_width  = CFG_RESET;
    logic [CFG_W-1:0] cfg_height = CFG_RESET;

    sobel_edge_filter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Zero means one, and anything past the limit acts as the limit.
    function automatic int clamp_dim(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Magnitude of the horizontal gradient of one channel, clamped to 255.
    function automatic logic [7:0] grad_mag(input logic [7:0] lt, lm, lb, rt, rm, rb);
        int g;
        g = (int'(rt) - int'(lt)) + 2 * (int'(rm) - int'(lm)) + (int'(rb) - int'(lb));
        if (g < 0) g = -g;
        return (g > 255) ? 8'hFF : g[7:0];
    endfunction

    // Advances the predictor by one pixel beat; returns 1 when it yields an edge beat.
    function automatic bit predict_edges(input t_pix_in px, output t_pix_out res);
        int   w, h, ir, ic, col;
        t_rgb pix;
        t_col fresh, lcol, rcol;
        bit   emit;
        w   = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h   = clamp_dim(cfg_height, HEIGHT_LIMIT);
        ir  = pos_row;
        ic  = pos_col;
        col = ic % MAX_WIDTH_DEF;
        res = '0;
        // Fill beats and beats past the last row enter as black.
        pix = '0;
        if (!px.fill && ir < h) pix = {px.red_in, px.green_in, px.blue_in};

        fresh.top = (ir >= 2) ? upper_line[col] : '0;
        fresh.mid = (ir >= 1) ? lower_line[col] : '0;
        fresh.bot = pix;
        upper_line[col] = fresh.mid;
        lower_line[col] = pix;
        emit = (ir >= 2) || (ir == 1 && ic >= 1);

        // Zero padding at a row start: right column of the last pixel, left column of the first.
        lcol = win_prior;
        if (ic == 0) begin
            rcol      = '0;
            win_prior = '0;
        end else begin
            rcol      = fresh;
            win_prior = win_newest;
        end
        win_newest = fresh;

        if (ic + 1 >= w) begin
            pos_col = 0;
            pos_row = (ir + 1 > int'(ROW_SAT)) ? int'(ROW_SAT) : ir + 1;
        end else begin
            pos_col = ic + 1;
        end
        if (!emit) return 0;

        res.red_edge   = grad_mag(lcol.top.red, lcol.mid.red, lcol.bot.red,
                                  rcol.top.red, rcol.mid.red, rcol.bot.red);
        res.green_edge = grad_mag(lcol.top.green, lcol.mid.green, lcol.bot.green,
                                  rcol.top.green, rcol.mid.green, rcol.bot.green);
        res.blue_edge  = grad_mag(lcol.top.blue, lcol.mid.blue, lcol.bot.blue,
                                  rcol.top.blue, rcol.mid.blue, rcol.bot.blue);
        // The frame closes on the edge beat that completes W*H outputs.
        if (emitted + 1 >= w * h) begin
            res.frame_end = 1'b1;
            pos_row    = 0;
            pos_col    = 0;
            emitted    = 0;
            win_newest = '0;
            win_prior  = '0;
        end else begin
            emitted = emitted + 1;
        end
        return 1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Pixel driver: offers queued beats, predicts each accepted beat.
    always @(posedge i_clk) begin : drive_pixels
        t_pix_out edge_beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (predict_edges(i_in_data, edge_beat)) edges_due.push_back(edge_beat);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pixels_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each edge beat and drives ready, with long holds on request.
    always @(posedge i_clk) begin : take_edges
        t_pix_out want;
        if (o_out_valid && i_out_ready) begin
            if (edges_due.size() == 0) begin
                $error("edge beat arrived with nothing expected");
                fail_count++;
            end else begin
                want = edges_due.pop_front();
                check_field("red_edge", want.red_edge, o_out_data.red_edge);
                check_field("green_edge", want.green_edge, o_out_data.green_edge);
                check_field("blue_edge", want.blue_edge, o_out_data.blue_edge);
                check_field("frame_end", want.frame_end, o_out_data.frame_end);
            end
        end
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any beat on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Waits until every pixel is taken and every edge beat is back, then lets the pipe drain.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pixels_to_send.size() != 0 || i_in_valid || edges_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) cfg_width = val;
        else cfg_height = val;
    endtask

    // Sets up a frame and queues its pixels and flush beats with random content.
    task automatic push_frame(input int wr, input int hr);
        int      w, h;
        t_pix_in px;
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, wr[CFG_W-1:0]);
        write_reg(CFG_IMAGE_HEIGHT, hr[CFG_W-1:0]);
        w = clamp_dim(wr, MAX_WIDTH_DEF);
        h = clamp_dim(hr, HEIGHT_LIMIT);
        for (int k = 0; k < w * h + w + 1; k++) begin
            px = t_pix_in'($urandom);
            if (k < w * h) begin
                // Saturated channels now and then, and the odd black fill beat.
                if ($urandom_range(0, 7) == 0) begin
                    px.red_in   = {8{px.red_in[7]}};
                    px.green_in = {8{px.green_in[7]}};
                    px.blue_in  = {8{px.blue_in[7]}};
                end
                px.fill = ($urandom_range(0, 39) == 0);
            end else begin
                px.fill = ($urandom_range(0, 9) != 0);
            end
            pixels_to_send.push_back(px);
        end
        queued_items += w * h + w + 1;
    endtask

    // Mostly small frames, now and then a very wide or very tall one.
    task automatic random_frames(input int budget);
        int first, wr, hr;
        first = queued_items;
        while (queued_items - first < budget) begin
            case ($urandom_range(0, 11))
                0: begin
                    wr = $urandom_range(0, 511);
                    hr = $urandom_range(0, 1);
                end
                1: begin
                    wr = $urandom_range(0, 1);
                    hr = $urandom_range(0, 511);
                end
                default: begin
                    wr = $urandom_range(1, 24);
                    hr = $urandom_range(1, 12);
                end
            endcase
            push_frame(wr, hr);
        end
    endtask

    initial begin
        int r, c, cnt, n, w, h;
        bit done;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Hand-picked 3x3 frame.
        write_reg(CFG_IMAGE_WIDTH, 9'd3);
        write_reg(CFG_IMAGE_HEIGHT, 9'd3);
        foreach (CORNER_FRAME[k]) pixels_to_send.push_back(CORNER_FRAME[k]);

        // Zero sizes act as a 1x1 frame; the second beat is a pixel past the last row.
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, 9'd0);
        write_reg(CFG_IMAGE_HEIGHT, 9'd0);
        pixels_to_send.push_back({8'hFF, 8'h80, 8'h01, 1'b0});
        pixels_to_send.push_back({8'hAB, 8'hCD, 8'hEF, 1'b0});
        pixels_to_send.push_back({8'h00, 8'h00, 8'h00, 1'b1});

        // Size change in the middle of a frame, then flush to the frame end.
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, 9'd4);
        write_reg(CFG_IMAGE_HEIGHT, 9'd3);
        repeat (6) pixels_to_send.push_back({24'($urandom), 1'b0});
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, 9'd2);
        write_reg(CFG_IMAGE_HEIGHT, 9'd2);
        r    = pos_row;
        c    = pos_col;
        cnt  = emitted;
        n    = 0;
        w    = clamp_dim(cfg_width, MAX_WIDTH_DEF);
        h    = clamp_dim(cfg_height, HEIGHT_LIMIT);
        done = 1'b0;
        while (!done) begin
            n++;
            if (r >= 2 || (r == 1 && c >= 1)) begin
                if (cnt + 1 >= w * h) done = 1'b1;
                cnt++;
            end
            if (c + 1 >= w) begin
                c = 0;
                r = r + 1;
            end else begin
                c = c + 1;
            end
        end
        repeat (n) pixels_to_send.push_back(t_pix_in'($urandom));

        // Slow receiver, widest frame with every width bit set.
        send_idle_pct <= 12;
        recv_idle_pct <= 76;
        push_frame(511, 1);
        random_frames(27);

        // Slow sender, tallest frame.
        send_idle_pct <= 76;
        recv_idle_pct <= 12;
        push_frame(1, 511);
        random_frames(280);

        // Full rate, with one long receiver hold while the sender keeps offering.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        push_frame(256, 1);
        @(posedge i_clk);
        hold_req <= hold_req + 1;
        random_frames(30);

        wait_quiet();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
